// File: rtl/nps_pkg.sv
// Shared types, constants and helpers for the nine-patch marker scanner.
// No dependencies; every other file imports this package.
package nps_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W         = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned COMP_W        = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned NUM_SCAN      = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [DIM_W-1:0]  DIM_MIN  = DIM_W'(3);
  localparam logic [DIM_W-1:0]  DIM_MAX  = DIM_W'(MAX_DIMENSION);
  localparam logic [COMP_W-1:0] COMP_MIN = COMP_W'(1);
  localparam logic [COMP_W-1:0] COMP_MAX = COMP_W'(4);

  localparam logic [7:0] BLACK_RGB   = 8'h00;
  localparam logic [7:0] BLACK_ALPHA = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_COMPS  = 2'd2
  } cfg_idx_e;

  // scanner order: top row, left column, bottom row, right column
  typedef enum logic [1:0] {
    SCAN_TOP    = 2'd0,
    SCAN_LEFT   = 2'd1,
    SCAN_BOTTOM = 2'd2,
    SCAN_RIGHT  = 2'd3
  } scan_id_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_BLACK  = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_REJECT = 2'd3
  } phase_e;

  // effective (saturated) configuration
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [COMP_W-1:0] comps;
  } cfg_t;

  // classified pixel, front to back
  typedef struct packed {
    logic             black;
    logic [NUM_SCAN-1:0] on_line;
    logic             last;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } pix_t;

  typedef struct packed {
    logic             stretch_valid;
    logic             content_valid;
    logic [DIM_W-1:0] border_left;
    logic [DIM_W-1:0] border_right;
    logic [DIM_W-1:0] border_top;
    logic [DIM_W-1:0] border_bottom;
    logic [DIM_W-1:0] margin_left;
    logic [DIM_W-1:0] margin_right;
    logic [DIM_W-1:0] margin_top;
    logic [DIM_W-1:0] margin_bottom;
    logic [DIM_W-1:0] tex_width;
    logic [DIM_W-1:0] tex_height;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > DIM_MAX) r = DIM_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] clamp_comps(logic [COMP_W-1:0] v);
    logic [COMP_W-1:0] r;
    if (v < COMP_MIN) r = COMP_MIN;
    else if (v > COMP_MAX) r = COMP_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] diff_sat(logic [DIM_W-1:0] size,
                                                logic [DIM_W-1:0] run_end);
    logic [DIM_W-1:0] r;
    if (run_end >= size) r = '0;
    else r = size - run_end;
    return r;
  endfunction

endpackage

// File: rtl/nps_front.sv
// Front end: accepts pixels, keeps the raster position and classifies each
// pixel (black test, which marker lines it sits on, end of image). Uses nps_pkg.
module nps_front import nps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  output logic       push_o,
  output pix_t       pix_o,
  input  logic       full_i
);

  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic             last_col, last_row, accept;
  logic [3:0]       byte_ok;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign last_col = col_q >= (cfg_i.width - DIM_W'(1));
  assign last_row = row_q >= (cfg_i.height - DIM_W'(1));

  // bytes beyond the component count always match
  assign byte_ok[0] = (red_i == BLACK_RGB);
  assign byte_ok[1] = (green_i == BLACK_RGB) || (cfg_i.comps < COMP_W'(2));
  assign byte_ok[2] = (blue_i == BLACK_RGB) || (cfg_i.comps < COMP_W'(3));
  assign byte_ok[3] = (alpha_i == BLACK_ALPHA) || (cfg_i.comps < COMP_W'(4));

  always_comb begin
    pix_o.black                = &byte_ok;
    pix_o.on_line[SCAN_TOP]    = (row_q == '0);
    pix_o.on_line[SCAN_LEFT]   = (col_q == '0);
    pix_o.on_line[SCAN_BOTTOM] = last_row;
    pix_o.on_line[SCAN_RIGHT]  = last_col;
    pix_o.last                 = last_col && last_row;
    pix_o.col                  = col_q;
    pix_o.row                  = row_q;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (!last_col) begin
        col_d = col_q + DIM_W'(1);
      end else if (!last_row) begin
        col_d = '0;
        row_d = row_q + DIM_W'(1);
      end else begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: rtl/nps_queue.sv
// Short queue of classified pixels between front and back.
// Depth from nps_pkg::QUEUE_DEPTH. Uses nps_pkg.
module nps_queue import nps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output pix_t data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: rtl/nps_back.sv
// Back end: four run scanners on the marker lines, result assembly at the
// last pixel, and the output register. Uses nps_pkg.
module nps_back import nps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  pix_t    pix_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  phase_e           phase_q [NUM_SCAN];
  phase_e           phase_d [NUM_SCAN];
  logic [DIM_W-1:0] start_q [NUM_SCAN];
  logic [DIM_W-1:0] start_d [NUM_SCAN];
  logic [DIM_W-1:0] end_q   [NUM_SCAN];
  logic [DIM_W-1:0] end_d   [NUM_SCAN];
  phase_e           ph_n    [NUM_SCAN];
  logic [DIM_W-1:0] st_n    [NUM_SCAN];
  logic [DIM_W-1:0] en_n    [NUM_SCAN];

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    load, top, bord, bottom, margins;

  // a finished image waits while the previous result is still unclaimed
  assign pop_o = valid_i && !(pix_i.last && out_valid_q && !out_ready_i);
  assign load  = pop_o && pix_i.last;

  // scanner step; top and bottom index by column, left and right by row
  always_comb begin
    for (int i = 0; i < NUM_SCAN; i++) begin
      logic [DIM_W-1:0] idx;
      idx   = (i[0] == 1'b0) ? pix_i.col : pix_i.row;
      ph_n[i] = phase_q[i];
      st_n[i] = start_q[i];
      en_n[i] = end_q[i];
      if (pix_i.on_line[i]) begin
        unique case (phase_q[i])
          PH_LEAD: begin
            if (pix_i.black) begin
              if (idx == '0) begin
                ph_n[i] = PH_REJECT;
              end else begin
                ph_n[i] = PH_BLACK;
                st_n[i] = idx;
              end
            end
          end
          PH_BLACK: begin
            if (!pix_i.black) begin
              ph_n[i] = PH_TRAIL;
              en_n[i] = idx;
            end
          end
          PH_TRAIL: begin
            if (pix_i.black) ph_n[i] = PH_REJECT;
          end
          PH_REJECT: ;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SCAN; i++) begin
      phase_d[i] = phase_q[i];
      start_d[i] = start_q[i];
      end_d[i]   = end_q[i];
      if (pop_o) begin
        if (pix_i.last) begin
          phase_d[i] = PH_LEAD;
          start_d[i] = '0;
          end_d[i]   = '0;
        end else begin
          phase_d[i] = ph_n[i];
          start_d[i] = st_n[i];
          end_d[i]   = en_n[i];
        end
      end
    end
  end

  // lines are judged in a chain
  assign top     = (ph_n[SCAN_TOP] == PH_TRAIL);
  assign bord    = top && (ph_n[SCAN_LEFT] == PH_TRAIL);
  assign bottom  = bord && (ph_n[SCAN_BOTTOM] == PH_TRAIL);
  assign margins = bottom && (ph_n[SCAN_RIGHT] == PH_TRAIL);

  always_comb begin
    res_d               = '0;
    res_d.stretch_valid = bord;
    res_d.content_valid = margins;
    if (top) begin
      res_d.border_left  = st_n[SCAN_TOP];
      res_d.border_right = diff_sat(cfg_i.width, en_n[SCAN_TOP]);
    end
    if (bord) begin
      res_d.border_top    = st_n[SCAN_LEFT];
      res_d.border_bottom = diff_sat(cfg_i.height, en_n[SCAN_LEFT]);
    end
    if (bottom) begin
      res_d.margin_left  = st_n[SCAN_BOTTOM];
      res_d.margin_right = diff_sat(cfg_i.width, en_n[SCAN_BOTTOM]);
    end
    if (margins) begin
      res_d.margin_top    = st_n[SCAN_RIGHT];
      res_d.margin_bottom = diff_sat(cfg_i.height, en_n[SCAN_RIGHT]);
      res_d.tex_width     = cfg_i.width - DIM_W'(2);
      res_d.tex_height    = cfg_i.height - DIM_W'(2);
    end else if (bord) begin
      res_d.tex_width  = cfg_i.width - DIM_W'(1);
      res_d.tex_height = cfg_i.height - DIM_W'(1);
    end else begin
      res_d.tex_width  = cfg_i.width;
      res_d.tex_height = cfg_i.height;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SCAN; i++) begin
        phase_q[i] <= PH_LEAD;
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NUM_SCAN; i++) begin
        phase_q[i] <= phase_d[i];
        start_q[i] <= start_d[i];
        end_q[i]   <= end_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/nine_patch_marker_scanner.sv
// Nine-patch marker scanner: takes one RGBA pixel per cycle in raster order and
// gives one result beat per image, registered once the image's last pixel has
// passed the pixel queue, unless the previous result is still waiting on
// out_ready_i. A pixel is taken every cycle while in_ready_o is high; the input
// stalls only when the two-entry pixel queue fills, which happens when a new
// image ends while the previous result is still waiting on out_ready_i. The
// result holds the stretch borders (top row and left column markers), the
// content margins (bottom row and right column markers), validity flags and the
// cropped texture size; a marker line that is not a non-black, black,
// non-black pattern reads as zero. Configuration writes are taken every cycle
// and must only happen between images. Depends on nps_pkg, nps_front,
// nps_queue and nps_back.
module nine_patch_marker_scanner import nps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [7:0]           alpha_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 stretch_valid_o,
  output logic                 content_valid_o,
  output logic [DIM_W-1:0]     border_left_o,
  output logic [DIM_W-1:0]     border_right_o,
  output logic [DIM_W-1:0]     border_top_o,
  output logic [DIM_W-1:0]     border_bottom_o,
  output logic [DIM_W-1:0]     margin_left_o,
  output logic [DIM_W-1:0]     margin_right_o,
  output logic [DIM_W-1:0]     margin_top_o,
  output logic [DIM_W-1:0]     margin_bottom_o,
  output logic [DIM_W-1:0]     tex_width_o,
  output logic [DIM_W-1:0]     tex_height_o
);

  logic [DIM_W-1:0]  width_q, height_q;
  logic [COMP_W-1:0] comps_q;
  cfg_t              cfg;
  logic              push, full, pop, q_valid;
  pix_t              pix_in, pix_head;
  result_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_DIMENSION);
      height_q <= DIM_W'(MAX_DIMENSION);
      comps_q  <= COMP_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_COMPS:  comps_q  <= cfg_data_i[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.width  = clamp_dim(width_q);
  assign cfg.height = clamp_dim(height_q);
  assign cfg.comps  = clamp_comps(comps_q);

  nps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .alpha_i    (alpha_i),
    .push_o     (push),
    .pix_o      (pix_in),
    .full_i     (full)
  );

  nps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pix_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pix_head)
  );

  nps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (q_valid),
    .pix_i       (pix_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign stretch_valid_o = res.stretch_valid;
  assign content_valid_o = res.content_valid;
  assign border_left_o   = res.border_left;
  assign border_right_o  = res.border_right;
  assign border_top_o    = res.border_top;
  assign border_bottom_o = res.border_bottom;
  assign margin_left_o   = res.margin_left;
  assign margin_right_o  = res.margin_right;
  assign margin_top_o    = res.margin_top;
  assign margin_bottom_o = res.margin_bottom;
  assign tex_width_o     = res.tex_width;
  assign tex_height_o    = res.tex_height;

endmodule

// File: rtl/nps_checker.sv
// Port-level checks for nine_patch_marker_scanner, attached by bind.
// Uses nps_pkg for field widths.
module nps_checker import nps_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             stretch_valid_o,
  input logic             content_valid_o,
  input logic [DIM_W-1:0] border_left_o,
  input logic [DIM_W-1:0] border_top_o,
  input logic [DIM_W-1:0] margin_left_o,
  input logic [DIM_W-1:0] margin_top_o,
  input logic [DIM_W-1:0] margin_bottom_o
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // and its border_left_o and margin_top_o payload fields do not move
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(border_left_o) && $stable(margin_top_o))
    else $error("result payload changed while stalled");

  a_margin_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && content_valid_o |-> stretch_valid_o)
    else $error("margins reported without border");

  a_no_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stretch_valid_o |-> border_top_o == '0 && margin_left_o == '0)
    else $error("border fields set without a valid border");

  a_no_margin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !content_valid_o |-> margin_top_o == '0 && margin_bottom_o == '0)
    else $error("right margin fields set without valid margins");

endmodule

bind nine_patch_marker_scanner nps_checker u_nps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .stretch_valid_o (stretch_valid_o),
  .content_valid_o (content_valid_o),
  .border_left_o   (border_left_o),
  .border_top_o    (border_top_o),
  .margin_left_o   (margin_left_o),
  .margin_top_o    (margin_top_o),
  .margin_bottom_o (margin_bottom_o)
);

// File: dv/nine_patch_marker_scanner_test.sv
// Self-checking bench for nine_patch_marker_scanner: streams RGBA images with marker
// lines and compares every result beat against a cycle-free scanner model.
// Depends on nps_pkg and the scanner RTL; needs no files or arguments.
module nine_patch_marker_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic [3:0][7:0] pixel_t;  // [0] red .. [3] alpha
  typedef bit line_flags_t [];

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           red_i       = '0;
  logic [7:0]           green_i     = '0;
  logic [7:0]           blue_i      = '0;
  logic [7:0]           alpha_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 stretch_valid_o;
  logic                 content_valid_o;
  logic [DIM_W-1:0]     border_left_o;
  logic [DIM_W-1:0]     border_right_o;
  logic [DIM_W-1:0]     border_top_o;
  logic [DIM_W-1:0]     border_bottom_o;
  logic [DIM_W-1:0]     margin_left_o;
  logic [DIM_W-1:0]     margin_right_o;
  logic [DIM_W-1:0]     margin_top_o;
  logic [DIM_W-1:0]     margin_bottom_o;
  logic [DIM_W-1:0]     tex_width_o;
  logic [DIM_W-1:0]     tex_height_o;

  nine_patch_marker_scanner DUT (.*);

  // register copies and scanner state of the model
  logic [DIM_W-1:0]  reg_width  = DIM_W'(MAX_DIMENSION);
  logic [DIM_W-1:0]  reg_height = DIM_W'(MAX_DIMENSION);
  logic [COMP_W-1:0] reg_comps  = COMP_W'(4);
  logic [DIM_W-1:0]  col_pos;
  logic [DIM_W-1:0]  row_pos;
  phase_e            line_phase [NUM_SCAN];
  logic [DIM_W-1:0]  run_first  [NUM_SCAN];
  logic [DIM_W-1:0]  run_stop   [NUM_SCAN];
  result_t           pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_started  = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int pixels_sent    = 0;
  int images_sent    = 0;
  int beats_checked  = 0;
  int mismatch_count = 0;

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] raw);
    if (raw < 3) return DIM_W'(3);
    if (raw > MAX_DIMENSION) return DIM_W'(MAX_DIMENSION);
    return raw;
  endfunction

  function automatic int eff_comps();
    if (reg_comps < 1) return 1;
    if (reg_comps > 4) return 4;
    return int'(reg_comps);
  endfunction

  function automatic logic [7:0] marker_byte(int k);
    return (k == 3) ? BLACK_ALPHA : BLACK_RGB;
  endfunction

  function automatic bit is_marker(pixel_t px);
    int k;
    for (k = 0; k < eff_comps(); k++)
      if (px[k] != marker_byte(k)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [DIM_W-1:0] gap_to_edge(logic [DIM_W-1:0] size,
                                                   logic [DIM_W-1:0] stop);
    return (stop >= size) ? '0 : size - stop;
  endfunction

  task automatic clear_scan_state();
    int s;
    col_pos = '0;
    row_pos = '0;
    for (s = 0; s < NUM_SCAN; s++) begin
      line_phase[s] = PH_LEAD;
      run_first[s]  = '0;
      run_stop[s]   = '0;
    end
  endtask

  task automatic step_line(scan_id_e s, logic [DIM_W-1:0] idx, bit blk);
    case (line_phase[s])
      PH_LEAD: if (blk) begin
        if (idx == 0) begin
          line_phase[s] = PH_REJECT;
        end else begin
          run_first[s]  = idx;
          line_phase[s] = PH_BLACK;
        end
      end
      PH_BLACK: if (!blk) begin
        run_stop[s]   = idx;
        line_phase[s] = PH_TRAIL;
      end
      PH_TRAIL: if (blk) line_phase[s] = PH_REJECT;
      default: ;
    endcase
  endtask

  // advance the model by one accepted pixel; queue a result at the image end
  task automatic scan_pixel(pixel_t px);
    logic [DIM_W-1:0] w, h;
    bit blk, end_col, end_row, top_ok, border_ok, bottom_ok, margins_ok;
    result_t res;
    w       = eff_dim(reg_width);
    h       = eff_dim(reg_height);
    blk     = is_marker(px);
    end_col = col_pos >= w - 1;
    end_row = row_pos >= h - 1;
    if (row_pos == 0) step_line(SCAN_TOP, col_pos, blk);
    if (col_pos == 0) step_line(SCAN_LEFT, row_pos, blk);
    if (end_row) step_line(SCAN_BOTTOM, col_pos, blk);
    if (end_col) step_line(SCAN_RIGHT, row_pos, blk);
    if (!end_col) begin
      col_pos++;
    end else if (!end_row) begin
      col_pos = '0;
      row_pos++;
    end else begin
      // each line only counts when the ones before it in the chain hold
      top_ok     = line_phase[SCAN_TOP] == PH_TRAIL;
      border_ok  = top_ok && line_phase[SCAN_LEFT] == PH_TRAIL;
      bottom_ok  = border_ok && line_phase[SCAN_BOTTOM] == PH_TRAIL;
      margins_ok = bottom_ok && line_phase[SCAN_RIGHT] == PH_TRAIL;
      res = '0;
      res.stretch_valid = border_ok;
      res.content_valid = margins_ok;
      if (top_ok) begin
        res.border_left  = run_first[SCAN_TOP];
        res.border_right = gap_to_edge(w, run_stop[SCAN_TOP]);
      end
      if (border_ok) begin
        res.border_top    = run_first[SCAN_LEFT];
        res.border_bottom = gap_to_edge(h, run_stop[SCAN_LEFT]);
      end
      if (bottom_ok) begin
        res.margin_left  = run_first[SCAN_BOTTOM];
        res.margin_right = gap_to_edge(w, run_stop[SCAN_BOTTOM]);
      end
      if (margins_ok) begin
        res.margin_top    = run_first[SCAN_RIGHT];
        res.margin_bottom = gap_to_edge(h, run_stop[SCAN_RIGHT]);
      end
      res.tex_width  = margins_ok ? w - DIM_W'(2) : (border_ok ? w - DIM_W'(1) : w);
      res.tex_height = margins_ok ? h - DIM_W'(2) : (border_ok ? h - DIM_W'(1) : h);
      pending_results.push_back(res);
      clear_scan_state();
    end
  endtask

  // ---------------------------------------------------------------- checking
  function automatic string field_note(string name, logic [DIM_W-1:0] want,
                                       logic [DIM_W-1:0] seen);
    if (want !== seen) return $sformatf(" %s exp %0d got %0d", name, want, seen);
    return "";
  endfunction

  function automatic string result_diffs(result_t want, result_t seen);
    return {field_note("stretch_valid", want.stretch_valid, seen.stretch_valid),
            field_note("content_valid", want.content_valid, seen.content_valid),
            field_note("border_left", want.border_left, seen.border_left),
            field_note("border_right", want.border_right, seen.border_right),
            field_note("border_top", want.border_top, seen.border_top),
            field_note("border_bottom", want.border_bottom, seen.border_bottom),
            field_note("margin_left", want.margin_left, seen.margin_left),
            field_note("margin_right", want.margin_right, seen.margin_right),
            field_note("margin_top", want.margin_top, seen.margin_top),
            field_note("margin_bottom", want.margin_bottom, seen.margin_bottom),
            field_note("tex_width", want.tex_width, seen.tex_width),
            field_note("tex_height", want.tex_height, seen.tex_height)};
  endfunction

  function automatic void report_failure(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t:%s", $time, what);
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t seen, want;
    string   diffs;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {stretch_valid_o, content_valid_o, border_left_o, border_right_o,
              border_top_o, border_bottom_o, margin_left_o, margin_right_o,
              margin_top_o, margin_bottom_o, tex_width_o, tex_height_o};
      if (pending_results.size() == 0) begin
        report_failure(" result beat with no image pending");
      end else begin
        want  = pending_results.pop_front();
        diffs = result_diffs(want, seen);
        beats_checked++;
        if (diffs != "") report_failure(diffs);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (holds_started != hold_requests) begin
      holds_started = hold_requests;
      hold_left     = LONG_HOLD;
    end
    if (!rst_ni || hold_left > 0) begin
      out_ready_i <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // valid stays up after the beat; callers either send again or lower it
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {alpha_i, blue_i, green_i, red_i} <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scan_pixel(px);
    pixels_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  reg_width  = data;
      CFG_HEIGHT: reg_height = data;
      CFG_COMPS:  reg_comps  = data[COMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                              logic [COMP_W-1:0] comps);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_COMPS, DIM_W'(comps));
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic pixel_t make_pixel(bit blk, int nc);
    pixel_t px;
    int     k;
    px = $urandom;
    if (blk || $urandom_range(1) == 1)
      for (k = 0; k < nc; k++) px[k] = marker_byte(k);
    if (!blk && is_marker(px)) begin
      // near miss: one bit off in one compared byte
      k     = $urandom_range(nc - 1);
      px[k] = px[k] ^ (8'd1 << $urandom_range(7));
    end
    return px;
  endfunction

  function automatic line_flags_t marker_line(int n, int good_pct);
    line_flags_t f;
    int lo, hi, i;
    f  = new[n];
    lo = $urandom_range(n - 2, 1);
    hi = $urandom_range(n - 1, lo + 1);
    if ($urandom_range(99) < good_pct) begin
      for (i = lo; i < hi; i++) f[i] = 1'b1;
    end else begin
      case ($urandom_range(3))
        0: ;                                       // no marker at all
        1: begin                                   // marker on the first pixel
          f[0] = 1'b1;
          for (i = lo; i < hi; i++) f[i] = 1'b1;
        end
        2: for (i = lo; i < n; i++) f[i] = 1'b1;   // run hits the line end
        default: foreach (f[j]) f[j] = $urandom_range(1);
      endcase
    end
    return f;
  endfunction

  task automatic send_image(int good_pct);
    int w, h, nc, r, c;
    line_flags_t top, left, bottom, right;
    bit blk;
    w      = eff_dim(reg_width);
    h      = eff_dim(reg_height);
    nc     = eff_comps();
    top    = marker_line(w, good_pct);
    bottom = marker_line(w, good_pct);
    left   = marker_line(h, good_pct);
    right  = marker_line(h, good_pct);
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
          blk = (r == 0 && top[c]) || (r == h - 1 && bottom[c]) ||
                (c == 0 && left[r]) || (c == w - 1 && right[r]);
        else
          blk = ($urandom_range(3) == 0);
        send_pixel(make_pixel(blk, nc));
      end
    end
    images_sent++;
  endtask

  // 3x3 image, bit i set puts a marker on raster pixel i
  task automatic send_pattern(logic [8:0] marks);
    int     i;
    pixel_t px;
    for (i = 0; i < 9; i++) begin
      case (i % 4)
        0:       px = 32'hFFFF_FFFF;
        1:       px = {8'hFE, 24'h00_0000};
        2:       px = 32'h0000_0000;
        default: px = {8'hFF, 8'h00, 8'hFF, 8'h00};
      endcase
      if (marks[i]) px = {BLACK_ALPHA, BLACK_RGB, BLACK_RGB, BLACK_RGB};
      send_pixel(px);
    end
    images_sent++;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed_patterns();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(3, 3, 4);
    send_pattern(9'b010_101_010);  // all four marker lines good
    send_pattern(9'b000_001_011);  // corner marker rejects top row and left column
    send_pattern(9'b100_101_010);  // border only: bottom and right runs both hit the end
  endtask

  task automatic test_component_counts();
    int c;
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    for (c = 0; c < 8; c++) begin
      set_geometry(DIM_W'($urandom_range(6)), DIM_W'($urandom_range(6)), COMP_W'(c));
      send_image(85);
    end
  endtask

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(9))
      0:       return DIM_W'($urandom_range(2));
      1:       return DIM_W'($urandom_range(16, 9));
      default: return DIM_W'($urandom_range(6, 3));
    endcase
  endfunction

  task automatic test_random_images(int budget, int idle_pct, int stall_pct);
    int first;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first          = pixels_sent;
    while (pixels_sent - first < budget) begin
      if ($urandom_range(2) == 0)
        set_geometry(random_dim(), random_dim(), COMP_W'($urandom_range(7)));
      send_image(85);
    end
  endtask

  // result output held off while small images keep coming: input must stall
  task automatic test_backpressure();
    int i;
    set_geometry(3, 3, 4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (i = 0; i < 6; i++) send_image(85);
    wait_idle();
  endtask

  task automatic test_long_lines();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(DIM_W'(32), 2, 4);
    send_image(85);
    set_geometry(1, DIM_W'(32), 3);
    send_image(85);
  endtask

  task automatic test_spare_register();
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    wait_idle();
    write_reg(CFG_WIDTH, 5);
    write_reg(CFG_HEIGHT, 3);
    write_reg(CFG_SPARE, DIM_W'($urandom));
    cfg_valid_i <= 1'b0;
    send_image(85);
    send_image(85);
  endtask

  initial begin
    clear_scan_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_patterns();
    test_component_counts();
    test_random_images(120, 0, 0);
    test_random_images(120, 68, 0);
    test_random_images(120, 0, 68);
    test_random_images(120, 29, 29);
    test_backpressure();
    test_long_lines();
    test_spare_register();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Streamed %0d pixels in %0d images, 3 to 32 pixels a side, clamped sizes,",
             pixels_sent, images_sent);
    $display("all component counts and stall mixes; %0d result beats, %0d mismatches",
             beats_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
